// ----- design/mst_pkg.sv -----
// Shared types and codes for the memory self-test sequencer.
`default_nettype none

package mst_pkg;

    localparam int unsigned CMD_W  = 3;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned DATA_W = 32;

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 72;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 25;

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_STATUS = 2'd1;
    localparam logic [1:0] REQ_RDWORD = 2'd2;

    localparam logic [3:0] ST_WR_OK    = 4'd0;
    localparam logic [3:0] ST_WR_FAIL  = 4'd1;
    localparam logic [3:0] ST_RD_OK    = 4'd2;
    localparam logic [3:0] ST_RD_FAIL  = 4'd3;
    localparam logic [3:0] ST_SLP_OK   = 4'd4;
    localparam logic [3:0] ST_SLP_FAIL = 4'd5;
    localparam logic [3:0] ST_WAK_OK   = 4'd6;
    localparam logic [3:0] ST_WAK_FAIL = 4'd7;
    localparam logic [3:0] ST_UNDEF    = 4'd8;

    localparam logic [2:0] CMD_WRITE_WORD = 3'd0;
    localparam logic [2:0] CMD_READ_CHUNK = 3'd1;
    localparam logic [2:0] CMD_SLEEP      = 3'd2;
    localparam logic [2:0] CMD_WAKEUP     = 3'd3;
    localparam logic [2:0] CMD_FINISHED   = 3'd4;
    localparam logic [2:0] CMD_MISMATCH   = 3'd5;
    localparam logic [2:0] CMD_SAFE       = 3'd6;
    localparam logic [2:0] CMD_INIT       = 3'd7;

    localparam logic [1:0] CFG_MEM_SIZE   = 2'd0;
    localparam logic [1:0] CFG_INIT_WAIT  = 2'd1;
    localparam logic [1:0] CFG_SLEEP_WAIT = 2'd2;
    localparam logic [1:0] CFG_SAFE_WAIT  = 2'd3;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] byte_address;
        logic [DATA_W-1:0] write_data;
        logic              last_of_run;
    } mst_result_t;

endpackage

`default_nettype wire

// ----- design/memory_self_test_sequencer.sv -----
// Memory self-test sequencer: phase control, write burst, read-back check, result queue.
//
// Items on the s_ channel are ticks, driver status reports and read-back words;
// the results of each go into a two-entry result queue that feeds the m_
// channel, so one item per cycle is accepted while earlier results wait,
// unless the queue is full or a write burst runs. A tick that opens or
// continues a chunk write produces up to 16 write-word transfers, one per
// cycle as the queue drains; s_tready stays low for that burst. Each word at
// byte address a carries a+4. Read-back words are checked on arrival.
// Configuration writes take effect at the clock edge.
`default_nettype none

module memory_self_test_sequencer #(
    parameter int unsigned CHUNK_WORDS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_wr_en,
    input  wire logic [mst_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [mst_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [2:0] status_code, [8:3] word_index, [40:9] read_data, rest zero
    input  wire logic [mst_pkg::S_TDATA_W-1:0]      s_tdata,
    // [1:0] req_type
    input  wire logic [mst_pkg::S_TUSER_W-1:0]      s_tuser,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [2:0] command, [34:3] byte_address, [66:35] write_data, rest zero
    output logic [mst_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                    m_tlast
);
    import mst_pkg::*;

    localparam logic [3:0] PH_INIT_T  = 4'd0;
    localparam logic [3:0] PH_INIT_P  = 4'd1;
    localparam logic [3:0] PH_TESTING = 4'd2;
    localparam logic [3:0] PH_WRITE_T = 4'd3;
    localparam logic [3:0] PH_WRITE_P = 4'd4;
    localparam logic [3:0] PH_READ_T  = 4'd5;
    localparam logic [3:0] PH_READ_P  = 4'd6;
    localparam logic [3:0] PH_CHECK   = 4'd7;
    localparam logic [3:0] PH_SLREQ_T = 4'd8;
    localparam logic [3:0] PH_SLREQ_P = 4'd9;
    localparam logic [3:0] PH_SLEEP_T = 4'd10;
    localparam logic [3:0] PH_SLEEP_P = 4'd11;
    localparam logic [3:0] PH_SAFE_T  = 4'd12;
    localparam logic [3:0] PH_SAFE_P  = 4'd13;

    localparam logic [15:0] CHUNK_TICKS = 16'(CHUNK_WORDS);
    localparam logic [6:0]  CHUNK_IDX   = 7'(CHUNK_WORDS);
    localparam logic [31:0] CHUNK_BYTES = 32'(4 * CHUNK_WORDS);
    localparam logic [3:0]  BURST_LAST  = 4'd15;

    logic [24:0] mem_size_reg;
    logic [15:0] init_wait_reg;
    logic [15:0] sleep_wait_reg;
    logic [15:0] safe_wait_reg;

    logic [3:0]             phase_reg, phase_next;
    logic [31:0]            block_addr_reg, block_addr_next;
    logic [3:0]             last_status_reg, last_status_next;
    logic [15:0]            phase_ticks_reg, phase_ticks_next;
    logic                   wakeup_sent_reg, wakeup_sent_next;
    logic [CHUNK_WORDS-1:0] arrived_reg, arrived_next;
    logic                   mismatch_reg, mismatch_next;
    logic                   burst_reg, burst_next;
    logic [3:0]             burst_cnt_reg, burst_cnt_next;

    mst_result_t q_mem [2];
    logic        q_wr_ptr_reg, q_rd_ptr_reg;
    logic [1:0]  q_count_reg;

    mst_result_t push_entry;
    logic        push_valid;
    logic        pop;
    logic        s_accept;
    logic        q_space;

    logic [1:0]  req_type;
    logic [2:0]  status_code;
    logic [5:0]  word_index;
    logic [31:0] read_data;

    logic [15:0] ticks_inc;
    logic [15:0] ticks_plus1;
    logic [31:0] word_addr;
    logic [31:0] expect_data;

    assign req_type    = s_tuser[1:0];
    assign status_code = s_tdata[2:0];
    assign word_index  = s_tdata[8:3];
    assign read_data   = s_tdata[40:9];

    assign s_tready = !burst_reg && (q_count_reg != 2'd2);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (q_count_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign q_space  = (q_count_reg != 2'd2) || pop;

    assign m_tdata = {5'd0, q_mem[q_rd_ptr_reg].write_data,
                      q_mem[q_rd_ptr_reg].byte_address, q_mem[q_rd_ptr_reg].command};
    assign m_tlast = q_mem[q_rd_ptr_reg].last_of_run;

    assign ticks_inc   = (phase_ticks_reg == TICKS_MAX) ? TICKS_MAX : phase_ticks_reg + 16'd1;
    assign ticks_plus1 = phase_ticks_reg + 16'd1;
    assign word_addr   = block_addr_reg + {14'd0, phase_ticks_reg, 2'b00};
    assign expect_data = block_addr_reg + {24'd0, word_index, 2'b00} + 32'd4;

    always_comb begin
        phase_next       = phase_reg;
        block_addr_next  = block_addr_reg;
        last_status_next = last_status_reg;
        phase_ticks_next = phase_ticks_reg;
        wakeup_sent_next = wakeup_sent_reg;
        arrived_next     = arrived_reg;
        mismatch_next    = mismatch_reg;
        burst_next       = burst_reg;
        burst_cnt_next   = burst_cnt_reg;
        push_valid       = 1'b0;
        push_entry       = '{command: CMD_INIT, byte_address: '0, write_data: '0,
                             last_of_run: 1'b1};

        if (burst_reg) begin
            if (q_space) begin
                push_valid                = 1'b1;
                push_entry.command        = CMD_WRITE_WORD;
                push_entry.byte_address   = word_addr;
                push_entry.write_data     = word_addr + 32'd4;
                push_entry.last_of_run    = 1'b0;
                phase_ticks_next          = ticks_plus1;
                burst_cnt_next            = burst_cnt_reg + 4'd1;
                if (ticks_plus1 >= CHUNK_TICKS || burst_cnt_reg == BURST_LAST) begin
                    burst_next             = 1'b0;
                    push_entry.last_of_run = 1'b1;
                    if (ticks_plus1 >= CHUNK_TICKS) begin
                        phase_next = PH_WRITE_P;
                    end
                end
            end
        end else if (s_accept) begin
            case (req_type)
                REQ_TICK: begin
                    case (phase_reg)
                        PH_INIT_T: begin
                            block_addr_next    = '0;
                            phase_ticks_next   = '0;
                            last_status_next   = ST_UNDEF;
                            wakeup_sent_next   = 1'b0;
                            push_valid         = 1'b1;
                            push_entry.command = CMD_INIT;
                            phase_next         = PH_INIT_P;
                        end
                        PH_INIT_P: begin
                            phase_ticks_next = ticks_inc;
                            if (ticks_inc >= init_wait_reg) begin
                                phase_next = PH_TESTING;
                            end
                        end
                        PH_TESTING: begin
                            if (block_addr_reg >= {7'd0, mem_size_reg}) begin
                                push_valid         = 1'b1;
                                push_entry.command = CMD_FINISHED;
                                phase_next         = PH_SLREQ_T;
                            end else begin
                                phase_ticks_next = '0;
                                phase_next       = PH_WRITE_T;
                            end
                        end
                        PH_WRITE_T: begin
                            if (phase_ticks_reg < CHUNK_TICKS) begin
                                burst_next     = 1'b1;
                                burst_cnt_next = '0;
                            end else begin
                                phase_next = PH_WRITE_P;
                            end
                        end
                        PH_WRITE_P: begin
                            if (last_status_reg == ST_WR_OK) phase_next = PH_READ_T;
                            if (last_status_reg == ST_WR_FAIL) phase_next = PH_SAFE_T;
                        end
                        PH_READ_T: begin
                            arrived_next            = '0;
                            mismatch_next           = 1'b0;
                            push_valid              = 1'b1;
                            push_entry.command      = CMD_READ_CHUNK;
                            push_entry.byte_address = block_addr_reg;
                            phase_next              = PH_READ_P;
                        end
                        PH_READ_P: begin
                            if (last_status_reg == ST_RD_OK) phase_next = PH_CHECK;
                            if (last_status_reg == ST_RD_FAIL) phase_next = PH_SAFE_T;
                        end
                        PH_CHECK: begin
                            if (!mismatch_reg && (&arrived_reg)) begin
                                block_addr_next = block_addr_reg + CHUNK_BYTES;
                                phase_next      = PH_TESTING;
                            end else begin
                                push_valid         = 1'b1;
                                push_entry.command = CMD_MISMATCH;
                                phase_next         = PH_SAFE_T;
                            end
                        end
                        PH_SLREQ_T: begin
                            push_valid         = 1'b1;
                            push_entry.command = CMD_SLEEP;
                            phase_next         = PH_SLREQ_P;
                        end
                        PH_SLREQ_P: begin
                            if (last_status_reg == ST_SLP_OK) phase_next = PH_SLEEP_T;
                            if (last_status_reg == ST_SLP_FAIL) phase_next = PH_SAFE_T;
                        end
                        PH_SLEEP_T: begin
                            phase_ticks_next = '0;
                            phase_next       = PH_SLEEP_P;
                        end
                        PH_SLEEP_P: begin
                            if (!wakeup_sent_reg) begin
                                phase_ticks_next = ticks_inc;
                                if (ticks_inc >= sleep_wait_reg) begin
                                    wakeup_sent_next   = 1'b1;
                                    push_valid         = 1'b1;
                                    push_entry.command = CMD_WAKEUP;
                                end
                            end
                            if (last_status_reg == ST_WAK_OK) phase_next = PH_INIT_T;
                            if (last_status_reg == ST_WAK_FAIL) phase_next = PH_SAFE_T;
                        end
                        PH_SAFE_T: begin
                            phase_ticks_next   = '0;
                            push_valid         = 1'b1;
                            push_entry.command = CMD_SAFE;
                            phase_next         = PH_SAFE_P;
                        end
                        PH_SAFE_P: begin
                            phase_ticks_next = ticks_inc;
                            if (ticks_inc >= safe_wait_reg) begin
                                phase_next = PH_INIT_T;
                            end
                        end
                        default: begin
                            phase_next = PH_INIT_T;
                        end
                    endcase
                end
                REQ_STATUS: begin
                    last_status_next = {1'b0, status_code};
                end
                REQ_RDWORD: begin
                    if (phase_reg == PH_READ_P && {1'b0, word_index} < CHUNK_IDX) begin
                        for (int i = 0; i < CHUNK_WORDS; i++) begin
                            if ({1'b0, word_index} == 7'(i)) begin
                                arrived_next[i] = 1'b1;
                            end
                        end
                        if (read_data != expect_data) begin
                            mismatch_next = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg    <= 25'd32768;
            init_wait_reg   <= 16'd10;
            sleep_wait_reg  <= 16'd10;
            safe_wait_reg   <= 16'd10;
            phase_reg       <= PH_INIT_T;
            block_addr_reg  <= '0;
            last_status_reg <= ST_UNDEF;
            phase_ticks_reg <= '0;
            wakeup_sent_reg <= 1'b0;
            arrived_reg     <= '0;
            mismatch_reg    <= 1'b0;
            burst_reg       <= 1'b0;
            burst_cnt_reg   <= '0;
            q_wr_ptr_reg    <= 1'b0;
            q_rd_ptr_reg    <= 1'b0;
            q_count_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_MEM_SIZE:   mem_size_reg   <= cfg_wdata;
                    CFG_INIT_WAIT:  init_wait_reg  <= cfg_wdata[15:0];
                    CFG_SLEEP_WAIT: sleep_wait_reg <= cfg_wdata[15:0];
                    CFG_SAFE_WAIT:  safe_wait_reg  <= cfg_wdata[15:0];
                    default: begin
                    end
                endcase
            end
            phase_reg       <= phase_next;
            block_addr_reg  <= block_addr_next;
            last_status_reg <= last_status_next;
            phase_ticks_reg <= phase_ticks_next;
            wakeup_sent_reg <= wakeup_sent_next;
            arrived_reg     <= arrived_next;
            mismatch_reg    <= mismatch_next;
            burst_reg       <= burst_next;
            burst_cnt_reg   <= burst_cnt_next;
            if (push_valid) begin
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            end
            if (pop) begin
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            end
            case ({push_valid, pop})
                2'b10:   q_count_reg <= q_count_reg + 2'd1;
                2'b01:   q_count_reg <= q_count_reg - 2'd1;
                default: q_count_reg <= q_count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            q_mem[q_wr_ptr_reg] <= push_entry;
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg != 2'd3)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (q_count_reg != 2'd2 || pop))
        else $error("transfer pushed into full result queue");

    a_burst_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        burst_reg |-> phase_reg == PH_WRITE_T)
        else $error("write burst outside write phase");

    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (burst_reg && !burst_next) |-> (push_valid && push_entry.last_of_run))
        else $error("write burst ended without last transfer");

endmodule

`default_nettype wire
